>>> src/pdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants of the PID differential drive unit
// Field widths, register indexes, reset values and the config struct.
// ----------------------------------------------------------------------------
package pdd_pkg;

	localparam int LEVEL_W   = 16;
	localparam int GAIN_W    = 12;
	localparam int SPEED_W   = 8;
	localparam int OUT_W     = 24;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_TARGET_LEVEL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_P       = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_I       = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_D       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BASE_SPEED   = 3'd4;

	localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST = 16'd5000;
	localparam logic [GAIN_W-1:0]  GAIN_P_RST       = 12'd307;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST       = 12'd256;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST       = 12'd26;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST   = 8'd50;

	typedef struct packed {
		logic [LEVEL_W-1:0] target_level;
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SPEED_W-1:0] base_speed;
	} pdd_cfg_t;

endpackage

>>> src/pdd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_regs: configuration register file
// APB-style write/read of setpoint, gains and base speed.
// ----------------------------------------------------------------------------
module pdd_regs import pdd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output pdd_cfg_t          cfg
);

	logic [LEVEL_W-1:0]   target_level_q;
	logic [GAIN_W-1:0]    gain_p_q;
	logic [GAIN_W-1:0]    gain_i_q;
	logic [GAIN_W-1:0]    gain_d_q;
	logic [SPEED_W-1:0]   base_speed_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_level_q <= TARGET_LEVEL_RST;
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			gain_d_q       <= GAIN_D_RST;
			base_speed_q   <= BASE_SPEED_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET_LEVEL: target_level_q <= pwdata[LEVEL_W-1:0];
				REG_GAIN_P:       gain_p_q       <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:       gain_i_q       <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:       gain_d_q       <= pwdata[GAIN_W-1:0];
				REG_BASE_SPEED:   base_speed_q   <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET_LEVEL: prdata = DATA_W'(target_level_q);
			REG_GAIN_P:       prdata = DATA_W'(gain_p_q);
			REG_GAIN_I:       prdata = DATA_W'(gain_i_q);
			REG_GAIN_D:       prdata = DATA_W'(gain_d_q);
			REG_BASE_SPEED:   prdata = DATA_W'(base_speed_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.target_level = target_level_q;
	assign cfg.gain_p       = gain_p_q;
	assign cfg.gain_i       = gain_i_q;
	assign cfg.gain_d       = gain_d_q;
	assign cfg.base_speed   = base_speed_q;

endmodule

>>> src/pdd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_core: PID datapath and loop state
// Error, three gain products, shift truncating toward zero, clamps, and the
// last-error / error-sum registers updated once per item.
// ----------------------------------------------------------------------------
module pdd_core import pdd_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pdd_cfg_t                cfg,
	input  logic [LEVEL_W-1:0]      red_a,
	input  logic [LEVEL_W-1:0]      red_b,
	input  logic                    update,
	output logic signed [OUT_W-1:0] control_value,
	output logic signed [OUT_W-1:0] left_drive,
	output logic signed [OUT_W-1:0] right_drive
);

	localparam int ERR_W  = LEVEL_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int ACC_W  = 32;
	localparam int IARG_W = ACC_W + 1;
	localparam int GS_W   = GAIN_W + 1;
	localparam int P_W    = GS_W + ERR_W;
	localparam int D_W    = GS_W + DIFF_W;
	localparam int I_W    = GS_W + IARG_W;
	localparam int TOT_W  = I_W + 1;
	localparam int SPD_W  = OUT_W + 2;

	localparam logic signed [TOT_W-1:0] TOT_HI = TOT_W'(2**(OUT_W-1) - 1);
	localparam logic signed [TOT_W-1:0] TOT_LO = TOT_W'(-(2**(OUT_W-1)));
	localparam logic signed [SPD_W-1:0] SPD_HI = SPD_W'(2**(OUT_W-1) - 1);
	localparam logic signed [SPD_W-1:0] SPD_LO = SPD_W'(-(2**(OUT_W-1)));

	logic signed [ERR_W-1:0]  last_error_q;
	logic signed [ACC_W-1:0]  error_sum_q;

	logic [LEVEL_W:0]         pair_sum;
	logic [LEVEL_W-1:0]       mean;
	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] diff;
	logic signed [IARG_W-1:0] iarg;
	logic signed [GS_W-1:0]   gp, gi, gd;
	logic signed [P_W-1:0]    p_term;
	logic signed [D_W-1:0]    d_term;
	logic signed [I_W-1:0]    i_term;
	logic signed [TOT_W-1:0]  total;
	logic                     tot_neg;
	logic [TOT_W-1:0]         mag;
	logic [TOT_W-1:0]         mag_shr;
	logic signed [TOT_W-1:0]  ctrl_w;
	logic signed [OUT_W-1:0]  ctrl;
	logic signed [SPD_W-1:0]  base_ext;
	logic signed [SPD_W-1:0]  left_w;
	logic signed [SPD_W-1:0]  right_w;

	function automatic logic signed [OUT_W-1:0] sat_tot(input logic signed [TOT_W-1:0] v);
		if (v > TOT_HI)
			return TOT_HI[OUT_W-1:0];
		else if (v < TOT_LO)
			return TOT_LO[OUT_W-1:0];
		else
			return v[OUT_W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat_spd(input logic signed [SPD_W-1:0] v);
		if (v > SPD_HI)
			return SPD_HI[OUT_W-1:0];
		else if (v < SPD_LO)
			return SPD_LO[OUT_W-1:0];
		else
			return v[OUT_W-1:0];
	endfunction

	assign pair_sum = {1'b0, red_a} + {1'b0, red_b};
	assign mean     = pair_sum[LEVEL_W:1];
	assign err      = $signed({1'b0, cfg.target_level}) - $signed({1'b0, mean});
	assign diff     = DIFF_W'(err) - DIFF_W'(last_error_q);
	assign iarg     = IARG_W'(err) + IARG_W'(error_sum_q);

	assign gp = $signed({1'b0, cfg.gain_p});
	assign gi = $signed({1'b0, cfg.gain_i});
	assign gd = $signed({1'b0, cfg.gain_d});

	assign p_term = P_W'(gp) * P_W'(err);
	assign d_term = D_W'(gd) * D_W'(diff);
	assign i_term = I_W'(gi) * I_W'(iarg);
	assign total  = TOT_W'(p_term) + TOT_W'(d_term) + TOT_W'(i_term);

	// shift magnitude so negative sums truncate toward zero
	assign tot_neg = total[TOT_W-1];
	assign mag     = tot_neg ? TOT_W'(-total) : TOT_W'(total);
	assign mag_shr = mag >> GAIN_FRAC_BITS;
	assign ctrl_w  = tot_neg ? -$signed(mag_shr) : $signed(mag_shr);
	assign ctrl    = sat_tot(ctrl_w);

	assign base_ext = $signed({{(SPD_W-SPEED_W){1'b0}}, cfg.base_speed});
	assign left_w   = base_ext + SPD_W'(ctrl);
	assign right_w  = base_ext - SPD_W'(ctrl);

	assign control_value = ctrl;
	assign left_drive    = sat_spd(left_w);
	assign right_drive   = sat_spd(right_w);

	logic signed [ACC_W:0] acc_w;
	assign acc_w = (ACC_W+1)'(error_sum_q) + (ACC_W+1)'(err);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (update) begin
			last_error_q <= err;
			if (acc_w[ACC_W] != acc_w[ACC_W-1])
				error_sum_q <= acc_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
				                            : {1'b0, {(ACC_W-1){1'b1}}};
			else
				error_sum_q <= acc_w[ACC_W-1:0];
		end
	end

endmodule

>>> src/pid_differential_drive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_differential_drive_unit: PID steering controller for a two-sensor drive
//
// Input channel (in_valid / in_stall) carries one item of two red readings.
// Output channel (out_valid / out_stall) returns one item per input: the
// saturated control value and the left and right wheel speeds.
// The APB-style port sets setpoint, Q4.8 gains and base speed; write it
// only while no item is in flight.
// Flow: an accepted item is held in the input register, then loaded into the
// result register once that register is free, and is taken from there.
// Throughput: one item per cycle while out_stall is low; the PID math runs in
// a single pass between the input register and the result register.
// While out_stall holds a result, one more item is taken into the input
// register, then in_stall rises until the result is taken.
// Reset: registers return to their reset values, the error history and
// error sum clear to zero, and both pipeline stages empty.
// ----------------------------------------------------------------------------
module pid_differential_drive_unit import pdd_pkg::*; #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [LEVEL_W-1:0]      red_a,
	input  logic [LEVEL_W-1:0]      red_b,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [OUT_W-1:0] control_value,
	output logic signed [OUT_W-1:0] left_drive,
	output logic signed [OUT_W-1:0] right_drive
);

	pdd_cfg_t                cfg;
	logic                    valid_s1;
	logic [LEVEL_W-1:0]      red_a_s1;
	logic [LEVEL_W-1:0]      red_b_s1;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] control_value_q;
	logic signed [OUT_W-1:0] left_drive_q;
	logic signed [OUT_W-1:0] right_drive_q;
	logic                    adv;
	logic                    in_acc;
	logic signed [OUT_W-1:0] ctrl_c;
	logic signed [OUT_W-1:0] left_c;
	logic signed [OUT_W-1:0] right_c;

	assign pready = 1'b1;

	pdd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// stage 1 moves into the result register when that register is empty or out_stall is low
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			red_a_s1 <= red_a;
			red_b_s1 <= red_b;
		end
	end

	pdd_core #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.red_a         (red_a_s1),
		.red_b         (red_b_s1),
		.update        (adv),
		.control_value (ctrl_c),
		.left_drive    (left_c),
		.right_drive   (right_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			control_value_q <= ctrl_c;
			left_drive_q    <= left_c;
			right_drive_q   <= right_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign control_value = control_value_q;
	assign left_drive    = left_drive_q;
	assign right_drive   = right_drive_q;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted item missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 && !(out_valid_q && out_stall)) |=> !out_valid_q)
		else $error("result appeared with no item in stage 1");

endmodule

>>> verif/tb_pid_differential_drive_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_differential_drive_unit: self-checking bench for the PID steering unit
// Drives red-reading items with random gaps and output stalls, predicts the
// control value and both wheel speeds from a local copy of the controller
// state, and compares every returned item in order. Register access goes
// through the APB-style port with read-back checks.
// ----------------------------------------------------------------------------
module tb_pid_differential_drive_unit;
	import pdd_pkg::*;

	localparam int     FRAC_BITS      = 8;
	localparam int     IDLE_MAX       = 8;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     DRAIN_CYCLES   = 6;
	localparam int     RAND_PHASES    = 8;
	localparam int     PHASE_ITEMS    = 170;
	localparam int     WIND_ITEMS     = 120;
	localparam longint OUT_HI         = 64'sd8388607;
	localparam longint OUT_LO         = -64'sd8388608;
	localparam longint SUM_HI         = 64'sd2147483647;
	localparam longint SUM_LO         = -64'sd2147483648;
	// indexes past the last register decode to nothing
	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic signed [OUT_W-1:0] ctrl;
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} steer_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_stall;
	logic [LEVEL_W-1:0]      red_a;
	logic [LEVEL_W-1:0]      red_b;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [OUT_W-1:0] control_value;
	logic signed [OUT_W-1:0] left_drive;
	logic signed [OUT_W-1:0] right_drive;

	pdd_cfg_t          cfg_model;
	logic signed [17:0] prev_error;
	logic signed [31:0] error_total;
	steer_t            expected_steering[$];

	int n_sent;
	int n_checked;
	int n_errors;
	int n_cfg_writes;
	int stall_left;
	int quiet_cycles;
	bit idle_on;
	bit stall_on;

	pid_differential_drive_unit #(
		.GAIN_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red_a        (red_a),
		.red_b        (red_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.control_value(control_value),
		.left_drive   (left_drive),
		.right_drive  (right_drive)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [LEVEL_W-1:0] clip_level(int v);
		if (v < 0) return '0;
		if (v > 65535) return '1;
		return LEVEL_W'(v);
	endfunction

	// one controller step: result fields plus history and integrator update
	function automatic steer_t predict_steering(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
		longint mean;
		longint err;
		longint total;
		longint ctrl;
		longint left;
		longint right;
		steer_t r;
		mean  = (longint'(a) + longint'(b)) >> 1;
		err   = longint'(cfg_model.target_level) - mean;
		total = longint'(cfg_model.gain_p) * err
			+ longint'(cfg_model.gain_i) * (err + longint'(error_total))
			+ longint'(cfg_model.gain_d) * (err - longint'(prev_error));
		// shift rounds toward zero on negative sums
		ctrl  = (total < 0) ? -((-total) >>> FRAC_BITS) : (total >>> FRAC_BITS);
		ctrl  = clamp(ctrl, OUT_LO, OUT_HI);
		left  = clamp(longint'(cfg_model.base_speed) + ctrl, OUT_LO, OUT_HI);
		right = clamp(longint'(cfg_model.base_speed) - ctrl, OUT_LO, OUT_HI);
		error_total = 32'(clamp(longint'(error_total) + err, SUM_LO, SUM_HI));
		prev_error  = 18'(err);
		r.ctrl  = OUT_W'(ctrl);
		r.left  = OUT_W'(left);
		r.right = OUT_W'(right);
		return r;
	endfunction

	task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TARGET_LEVEL: cfg_model.target_level = data[LEVEL_W-1:0];
			REG_GAIN_P:       cfg_model.gain_p       = data[GAIN_W-1:0];
			REG_GAIN_I:       cfg_model.gain_i       = data[GAIN_W-1:0];
			REG_GAIN_D:       cfg_model.gain_d       = data[GAIN_W-1:0];
			REG_BASE_SPEED:   cfg_model.base_speed   = data[SPEED_W-1:0];
			default: ;
		endcase
		n_cfg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_read(input logic [REG_IDX_W-1:0] idx);
		logic [DATA_W-1:0] want;
		case (idx)
			REG_TARGET_LEVEL: want = DATA_W'(cfg_model.target_level);
			REG_GAIN_P:       want = DATA_W'(cfg_model.gain_p);
			REG_GAIN_I:       want = DATA_W'(cfg_model.gain_i);
			REG_GAIN_D:       want = DATA_W'(cfg_model.gain_d);
			REG_BASE_SPEED:   want = DATA_W'(cfg_model.base_speed);
			default:          want = '0;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			n_errors++;
			$display("%0t register %0d read mismatch: expected %0d, got %0d",
				$time, idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// present one item after a random gap and hold it until taken
	task automatic send_reading(input logic [LEVEL_W-1:0] a, input logic [LEVEL_W-1:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		red_a    <= a;
		red_b    <= b;
		do @(posedge clk); while (in_stall);
		expected_steering.push_back(predict_steering(a, b));
		n_sent++;
	endtask

	// block idle: nothing pending and the pipeline given time to empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_steering.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string label, input logic signed [OUT_W-1:0] want,
		input logic signed [OUT_W-1:0] got);
		if (got !== want) begin
			n_errors++;
			$display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		steer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_steering.size() == 0) begin
				n_errors++;
				$display("%0t unexpected item: expected none, got control_value %0d",
					$time, control_value);
			end else begin
				want = expected_steering.pop_front();
				check_field("control_value", want.ctrl, control_value);
				check_field("left_drive", want.left, left_drive);
				check_field("right_drive", want.right, right_drive);
				n_checked++;
			end
			stall_left = stall_on ? $urandom_range(0, IDLE_MAX) : 0;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_reset_values();
		for (int i = REG_TARGET_LEVEL; i <= REG_BASE_SPEED; i++)
			cfg_read(REG_IDX_W'(i));
		idle_on  = 1'b1;
		stall_on = 1'b1;
		send_reading(16'd0, 16'd0);
		send_reading(16'hFFFF, 16'hFFFF);
		send_reading(16'hFFFF, 16'd0);
		send_reading(16'd0, 16'd1);      // odd sum, mean floors
		send_reading(16'd10000, 16'd0);  // zero error
		send_reading(16'd9999, 16'd10000);
		send_reading(16'd12345, 16'd54321);
	endtask

	// all-ones data also exercises upper bits that must be dropped
	task automatic test_register_access();
		drain();
		for (int i = REG_TARGET_LEVEL; i <= REG_BASE_SPEED; i++) begin
			cfg_write(REG_IDX_W'(i), '1);
			cfg_read(REG_IDX_W'(i));
		end
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			cfg_write(REG_IDX_W'(i), '0);
		for (int i = REG_TARGET_LEVEL; i <= REG_BASE_SPEED; i++) begin
			cfg_read(REG_IDX_W'(i));
			cfg_write(REG_IDX_W'(i), 32'hA5A5_0000);
			cfg_read(REG_IDX_W'(i));
		end
		for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
			cfg_write(REG_IDX_W'(i), '1);
		for (int i = REG_TARGET_LEVEL; i <= REG_BASE_SPEED; i++)
			cfg_read(REG_IDX_W'(i));
	endtask

	task automatic test_directed_corners();
		drain();
		// unit P gain only: small negative errors show truncation toward zero
		cfg_write(REG_TARGET_LEVEL, 32'd100);
		cfg_write(REG_GAIN_P, 32'd1);
		cfg_write(REG_GAIN_I, 32'd0);
		cfg_write(REG_GAIN_D, 32'd0);
		cfg_write(REG_BASE_SPEED, 32'd0);
		send_reading(16'd101, 16'd101);
		send_reading(16'd102, 16'd102);
		send_reading(16'd356, 16'd356);
		send_reading(16'd357, 16'd357);
		drain();
		// full gains, worst error both ways: outputs hit the rails
		cfg_write(REG_TARGET_LEVEL, 32'd65535);
		cfg_write(REG_GAIN_P, 32'd4095);
		cfg_write(REG_GAIN_I, 32'd4095);
		cfg_write(REG_GAIN_D, 32'd4095);
		cfg_write(REG_BASE_SPEED, 32'd255);
		repeat (8) send_reading(16'd0, 16'd0);
		drain();
		cfg_write(REG_TARGET_LEVEL, 32'd0);
		repeat (4) send_reading(16'hFFFF, 16'hFFFF);
	endtask

	// I-only with unit gain, so control_value follows the sum as it winds
	// down at full error and back up past zero
	task automatic test_integrator_windup();
		drain();
		idle_on  = 1'b0;
		stall_on = 1'b0;
		cfg_write(REG_GAIN_P, 32'd0);
		cfg_write(REG_GAIN_I, 32'd1);
		cfg_write(REG_GAIN_D, 32'd0);
		cfg_write(REG_BASE_SPEED, 32'd255);
		cfg_write(REG_TARGET_LEVEL, 32'd0);
		repeat (WIND_ITEMS) send_reading(16'hFFFF, 16'hFFFF);
		drain();
		cfg_write(REG_TARGET_LEVEL, 32'd65535);
		repeat (2 * WIND_ITEMS) send_reading(16'd0, 16'd0);
		drain();
		cfg_write(REG_TARGET_LEVEL, 32'd0);
		repeat (8) send_reading(16'hFFFF, 16'hFFFF);
	endtask

	function automatic logic [DATA_W-1:0] pick_setting();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return DATA_W'($urandom_range(0, 300));
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_tracking();
		logic [LEVEL_W-1:0] a;
		logic [LEVEL_W-1:0] b;
		int spread;
		int pick;
		int t;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			for (int i = REG_TARGET_LEVEL; i <= REG_BASE_SPEED; i++)
				cfg_write(REG_IDX_W'(i), pick_setting());
			if ($urandom_range(0, 1))
				cfg_write(REG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
			cfg_read(REG_IDX_W'($urandom_range(REG_TARGET_LEVEL, REG_BASE_SPEED)));
			t = int'(cfg_model.target_level);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					idle_on  = ($urandom_range(0, 3) != 0);
					stall_on = ($urandom_range(0, 3) != 0);
				end
				pick = $urandom_range(0, 19);
				if (pick < 12) begin
					// loop tracking the line: readings scattered around the setpoint
					spread = (pick < 6) ? 16 : (pick < 10) ? 256 : 4096;
					a = clip_level(t - spread + int'($urandom_range(0, 2 * spread)));
					b = clip_level(t - spread + int'($urandom_range(0, 2 * spread)));
				end else if (pick < 17) begin
					a = LEVEL_W'($urandom);
					b = LEVEL_W'($urandom);
				end else begin
					a = $urandom_range(0, 1) ? '1 : '0;
					b = $urandom_range(0, 1) ? '1 : '0;
				end
				send_reading(a, b);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		red_a      = '0;
		red_b      = '0;
		out_stall  = 1'b0;
		stall_left = 0;
		idle_on    = 1'b0;
		stall_on   = 1'b0;
		n_sent       = 0;
		n_checked    = 0;
		n_errors     = 0;
		n_cfg_writes = 0;
		quiet_cycles = 0;
		cfg_model.target_level = TARGET_LEVEL_RST;
		cfg_model.gain_p       = GAIN_P_RST;
		cfg_model.gain_i       = GAIN_I_RST;
		cfg_model.gain_d       = GAIN_D_RST;
		cfg_model.base_speed   = BASE_SPEED_RST;
		prev_error  = '0;
		error_total = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_register_access();
		test_directed_corners();
		test_integrator_windup();
		test_random_tracking();
		drain();

		$display("Run: %0d items sent, %0d results checked, %0d register writes, %0d mismatches",
			n_sent, n_checked, n_cfg_writes, n_errors);
		$display("%s%s", "Covered reset values, register masking, truncation, output clamps,",
			" integrator wind-up, random setpoints with gaps and stalls");
		if (n_errors == 0 && expected_steering.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/pdd_pkg.sv
src/pdd_regs.sv
src/pdd_core.sv
src/pid_differential_drive_unit.sv
verif/tb_pid_differential_drive_unit.sv
